// ===== rtl/ookenc_pkg.sv =====
// Package for the OOK remote frame encoder: phase and status codes, frame constants.
package ookenc_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SYNC = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_WRAP = 2'd1,
        ST_BAND     = 2'd2,
        ST_BUSY     = 2'd3
    } status_t;

    localparam logic [7:0]  HEADER_OK      = 8'hFD;
    localparam logic [7:0]  END_OK         = 8'hDF;
    localparam logic [7:0]  BAND_433       = 8'hF4;
    localparam logic [15:0] UNIT_TICKS_RST = 16'd320;
    localparam logic [4:0]  SYNC_LOW_UNITS = 5'd24;
    localparam logic [4:0]  FRAME_BITS     = 5'd24;
    localparam int          FRAME_W        = 24;

    localparam logic        CFG_UNIT_TICKS = 1'b0;

endpackage

// ===== rtl/ook_remote_frame_encoder.sv =====
// OOK remote frame encoder: command check, pulse-width waveform sequencer, result register.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------------------
//  in      | in        | in_valid / in_ready    | func header freq_code repeat_count address
//          |           |                        | key_value end_marker
//  out     | out       | out_valid / out_ready  | pin_level busy_res status
//  cfg     | in        | psel penable pwrite    | paddr pwdata prdata (unit_ticks at 0x0)
//
// One transaction per cycle unless the output stalls: the sequencer state advances at the
// accepting edge and the result is held in the output register, visible the next cycle.
// in_ready is high while the output register is empty or being drained.
// A stalled output holds its result and blocks further input only then.
// rst_n clears all control state; unit_ticks resets to 320.
module ook_remote_frame_encoder
    import ookenc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [7:0]  header,
    input  logic [7:0]  freq_code,
    input  logic [7:0]  repeat_count,
    input  logic [15:0] address,
    input  logic [7:0]  key_value,
    input  logic [7:0]  end_marker,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        pin_level,
    output logic        busy_res,
    output logic [1:0]  status,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0]        unit_ticks_reg;
    logic [FRAME_W-1:0] frame_shift_reg, frame_shift_next;
    logic [FRAME_W-1:0] saved_frame_reg, saved_frame_next;
    logic [4:0]         bits_left_reg, bits_left_next;
    phase_t             phase_reg, phase_next;
    logic               high_part_reg, high_part_next;
    logic [4:0]         units_left_reg, units_left_next;
    logic [15:0]        tick_prescale_reg, tick_prescale_next;
    logic [7:0]         repeats_left_reg, repeats_left_next;

    logic               out_valid_reg;
    logic               pin_level_reg, pin_level_next;
    logic               busy_res_reg, busy_res_next;
    status_t            status_reg, status_next;

    logic               accept;
    logic               busy;
    logic [15:0]        limit;
    logic [15:0]        presc_inc;
    logic [4:0]         units_dec;
    logic [4:0]         bits_dec;
    logic [7:0]         reps_dec;
    logic [FRAME_W-1:0] shifted;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == CFG_UNIT_TICKS) ? {16'd0, unit_ticks_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_ticks_reg <= UNIT_TICKS_RST;
        end
        else if (cfg_write && paddr[2] == CFG_UNIT_TICKS)
        begin
            unit_ticks_reg <= pwdata[15:0];
        end
    end

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign busy     = (phase_reg != PH_IDLE);

    assign limit     = (unit_ticks_reg == 16'd0) ? 16'd1 : unit_ticks_reg;
    assign presc_inc = tick_prescale_reg + 16'd1;
    assign units_dec = units_left_reg - 5'd1;
    assign bits_dec  = bits_left_reg - 5'd1;
    assign reps_dec  = repeats_left_reg - 8'd1;
    assign shifted   = {frame_shift_reg[FRAME_W-2:0], 1'b0};

    always_comb
    begin
        frame_shift_next   = frame_shift_reg;
        saved_frame_next   = saved_frame_reg;
        bits_left_next     = bits_left_reg;
        phase_next         = phase_reg;
        high_part_next     = high_part_reg;
        units_left_next    = units_left_reg;
        tick_prescale_next = tick_prescale_reg;
        repeats_left_next  = repeats_left_reg;
        status_next        = ST_OK;

        if (!func)
        begin
            if (busy)
            begin
                if (presc_inc < limit)
                begin
                    tick_prescale_next = presc_inc;
                end
                else
                begin
                    tick_prescale_next = 16'd0;
                    units_left_next    = units_dec;
                    if (units_dec == 5'd0)
                    begin
                        if (high_part_reg)
                        begin
                            high_part_next = 1'b0;
                            if (phase_reg == PH_SYNC)
                                units_left_next = SYNC_LOW_UNITS;
                            else
                                units_left_next = frame_shift_reg[FRAME_W-1] ? 5'd1 : 5'd2;
                        end
                        else if (phase_reg == PH_SYNC)
                        begin
                            phase_next      = PH_DATA;
                            bits_left_next  = FRAME_BITS;
                            high_part_next  = 1'b1;
                            units_left_next = frame_shift_reg[FRAME_W-1] ? 5'd2 : 5'd1;
                        end
                        else
                        begin
                            frame_shift_next = shifted;
                            bits_left_next   = bits_dec;
                            if (bits_dec != 5'd0)
                            begin
                                high_part_next  = 1'b1;
                                units_left_next = shifted[FRAME_W-1] ? 5'd2 : 5'd1;
                            end
                            else
                            begin
                                repeats_left_next = reps_dec;
                                if (reps_dec != 8'd0)
                                begin
                                    frame_shift_next   = saved_frame_reg;
                                    phase_next         = PH_SYNC;
                                    high_part_next     = 1'b1;
                                    units_left_next    = 5'd1;
                                    tick_prescale_next = 16'd0;
                                end
                                else
                                begin
                                    phase_next       = PH_IDLE;
                                    high_part_next   = 1'b0;
                                    units_left_next  = 5'd0;
                                    frame_shift_next = '0;
                                end
                            end
                        end
                    end
                end
            end
        end
        else
        begin
            if (busy)
            begin
                status_next = ST_BUSY;
            end
            else if (header != HEADER_OK || end_marker != END_OK)
            begin
                status_next = ST_BAD_WRAP;
            end
            else if (freq_code != BAND_433)
            begin
                status_next = ST_BAND;
            end
            else if (repeat_count != 8'd0)
            begin
                saved_frame_next   = {address, key_value};
                frame_shift_next   = {address, key_value};
                repeats_left_next  = repeat_count;
                bits_left_next     = 5'd0;
                phase_next         = PH_SYNC;
                high_part_next     = 1'b1;
                units_left_next    = 5'd1;
                tick_prescale_next = 16'd0;
            end
        end
    end

    always_comb
    begin
        if (!func)
        begin
            pin_level_next = busy && high_part_reg;
            busy_res_next  = busy;
        end
        else
        begin
            pin_level_next = 1'b0;
            busy_res_next  = (phase_next != PH_IDLE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_shift_reg   <= '0;
            saved_frame_reg   <= '0;
            bits_left_reg     <= 5'd0;
            phase_reg         <= PH_IDLE;
            high_part_reg     <= 1'b0;
            units_left_reg    <= 5'd0;
            tick_prescale_reg <= 16'd0;
            repeats_left_reg  <= 8'd0;
        end
        else if (accept)
        begin
            frame_shift_reg   <= frame_shift_next;
            saved_frame_reg   <= saved_frame_next;
            bits_left_reg     <= bits_left_next;
            phase_reg         <= phase_next;
            high_part_reg     <= high_part_next;
            units_left_reg    <= units_left_next;
            tick_prescale_reg <= tick_prescale_next;
            repeats_left_reg  <= repeats_left_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pin_level_reg <= pin_level_next;
            busy_res_reg  <= busy_res_next;
            status_reg    <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign pin_level = pin_level_reg;
    assign busy_res  = busy_res_reg;
    assign status    = status_reg;

    // idle means no pending part
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (!high_part_reg && units_left_reg == 5'd0))
        else $error("idle phase with pending part");

    a_busy_reps: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (repeats_left_reg != 8'd0 && units_left_reg != 5'd0))
        else $error("active phase without repeats or units");

    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_BUSY) |-> busy_res_reg)
        else $error("busy reject reported while idle");

    a_pin_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !busy_res_reg) |-> !pin_level_reg)
        else $error("pin driven while idle");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(phase_reg) && $stable(frame_shift_reg))
        else $error("sequencer moved without a transaction");

endmodule

// ===== tb/ook_frame_sb_pkg.sv =====
// Transaction types and pulse-width waveform scoreboard for the OOK frame encoder bench.
`timescale 1ns / 100ps
package ook_frame_sb_pkg;
    import ookenc_pkg::*;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_FRAME = 1'b1;

    typedef struct packed {
        logic        func;
        logic [7:0]  header;
        logic [7:0]  freq_code;
        logic [7:0]  repeat_count;
        logic [15:0] address;
        logic [7:0]  key_value;
        logic [7:0]  end_marker;
    } ook_cmd_t;

    typedef struct packed {
        logic    pin_level;
        logic    busy_res;
        status_t status;
    } pin_result_t;

    class ook_frame_scoreboard;
        logic [15:0] unit_ticks;
        logic [23:0] frame_shift;
        logic [23:0] saved_frame;
        logic [4:0]  bits_left;
        logic [4:0]  units_left;
        phase_t      phase;
        logic        high_part;
        logic [15:0] tick_prescale;
        logic [7:0]  repeats_left;
        pin_result_t expected_pins[$];
        int          errors;

        function new();
            unit_ticks    = UNIT_TICKS_RST;
            frame_shift   = '0;
            saved_frame   = '0;
            bits_left     = '0;
            units_left    = '0;
            phase         = PH_IDLE;
            high_part     = 1'b0;
            tick_prescale = '0;
            repeats_left  = '0;
            errors        = 0;
        endfunction

        function void set_unit_ticks(input logic [15:0] value);
            unit_ticks = value;
        endfunction

        function bit is_busy();
            return phase != PH_IDLE;
        endfunction

        function int pending();
            return expected_pins.size();
        endfunction

        function void start_sync();
            frame_shift   = saved_frame;
            phase         = PH_SYNC;
            high_part     = 1'b1;
            units_left    = 5'd1;
            tick_prescale = '0;
        endfunction

        function void start_symbol();
            high_part  = 1'b1;
            units_left = frame_shift[23] ? 5'd2 : 5'd1;
        endfunction

        function void end_of_part();
            if (high_part)
            begin
                high_part = 1'b0;
                if (phase == PH_SYNC)
                    units_left = SYNC_LOW_UNITS;
                else
                    units_left = frame_shift[23] ? 5'd1 : 5'd2;
            end
            else if (phase == PH_SYNC)
            begin
                phase     = PH_DATA;
                bits_left = FRAME_BITS;
                start_symbol();
            end
            else
            begin
                frame_shift = frame_shift << 1;
                bits_left   = bits_left - 5'd1;
                if (bits_left != 5'd0)
                    start_symbol();
                else
                begin
                    repeats_left = repeats_left - 8'd1;
                    if (repeats_left != 8'd0)
                        start_sync();
                    else
                    begin
                        phase       = PH_IDLE;
                        high_part   = 1'b0;
                        units_left  = '0;
                        frame_shift = '0;
                    end
                end
            end
        endfunction

        function void advance_tick();
            int limit;
            limit = (unit_ticks == 16'd0) ? 1 : int'(unit_ticks);
            tick_prescale = tick_prescale + 16'd1;
            if (int'(tick_prescale) < limit)
                return;
            tick_prescale = '0;
            units_left    = units_left - 5'd1;
            if (units_left == 5'd0)
                end_of_part();
        endfunction

        function void note_transaction(input ook_cmd_t c);
            pin_result_t r;
            logic        busy;
            busy        = (phase != PH_IDLE);
            r.pin_level = 1'b0;
            r.status    = ST_OK;
            if (c.func == FUNC_TICK)
            begin
                if (busy)
                begin
                    r.pin_level = high_part;
                    advance_tick();
                end
                r.busy_res = busy;
            end
            else
            begin
                if (busy)
                    r.status = ST_BUSY;
                else if (c.header != HEADER_OK || c.end_marker != END_OK)
                    r.status = ST_BAD_WRAP;
                else if (c.freq_code != BAND_433)
                    r.status = ST_BAND;
                else if (c.repeat_count != 8'd0)
                begin
                    saved_frame  = {c.address, c.key_value};
                    repeats_left = c.repeat_count;
                    bits_left    = '0;
                    start_sync();
                end
                r.busy_res = (phase != PH_IDLE);
            end
            expected_pins.push_back(r);
        endfunction

        function void check_result(input logic pin, input logic busy, input logic [1:0] st);
            pin_result_t want;
            if (expected_pins.size() == 0)
            begin
                $error("result with no transaction pending: pin_level %0b busy_res %0b status %0d",
                       pin, busy, st);
                errors++;
                return;
            end
            want = expected_pins.pop_front();
            if (pin !== want.pin_level)
            begin
                $error("pin_level expected %0b actual %0b", want.pin_level, pin);
                errors++;
            end
            if (busy !== want.busy_res)
            begin
                $error("busy_res expected %0b actual %0b", want.busy_res, busy);
                errors++;
            end
            if (st !== want.status)
            begin
                $error("status expected %0d actual %0d", want.status, st);
                errors++;
            end
        endfunction
    endclass

endpackage

// ===== tb/tb_ook_remote_frame_encoder.sv =====
// Top-level bench for the OOK frame encoder: clock, reset, APB setup, stimulus and checking.
`timescale 1ns / 100ps
module tb_ook_remote_frame_encoder;
    import ookenc_pkg::*;
    import ook_frame_sb_pkg::*;

    localparam int          CYCLE_LIMIT     = 1000000;
    localparam int          HOLD_CYCLES     = 400;
    localparam int          END_WAIT        = 16;
    localparam logic [2:0]  UNIT_TICKS_ADDR = 3'(CFG_UNIT_TICKS) * 3'd4;
    localparam logic [2:0]  UNUSED_ADDR     = 3'd4;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    ook_cmd_t    drv;
    logic        out_valid;
    logic        out_ready;
    logic        pin_level;
    logic        busy_res;
    logic [1:0]  status;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ook_frame_scoreboard sb;
    int                  tx_idle_pct;
    int                  rx_idle_pct;
    int                  cfg_errors;
    int                  cycles;
    bit                  hold_req;

    ook_remote_frame_encoder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (drv.func),
        .header       (drv.header),
        .freq_code    (drv.freq_code),
        .repeat_count (drv.repeat_count),
        .address      (drv.address),
        .key_value    (drv.key_value),
        .end_marker   (drv.end_marker),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pin_level    (pin_level),
        .busy_res     (busy_res),
        .status       (status),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d results pending", cycles, sb.pending());
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_transaction(drv);
            if (out_valid && out_ready)
                sb.check_result(pin_level, busy_res, status);
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic ook_cmd_t random_fields();
        ook_cmd_t c;
        c.func         = 1'($urandom_range(1));
        c.header       = 8'($urandom);
        c.freq_code    = 8'($urandom);
        c.repeat_count = 8'($urandom);
        c.address      = 16'($urandom);
        c.key_value    = 8'($urandom);
        c.end_marker   = 8'($urandom);
        return c;
    endfunction

    function automatic ook_cmd_t tick_item();
        ook_cmd_t c;
        c      = random_fields();
        c.func = FUNC_TICK;
        return c;
    endfunction

    function automatic ook_cmd_t frame_cmd(input logic [7:0] reps, input logic [15:0] addr,
                                           input logic [7:0] key);
        ook_cmd_t c;
        c              = random_fields();
        c.func         = FUNC_FRAME;
        c.header       = HEADER_OK;
        c.freq_code    = BAND_433;
        c.end_marker   = END_OK;
        c.repeat_count = reps;
        c.address      = addr;
        c.key_value    = key;
        return c;
    endfunction

    // rejected or empty commands; never starts a transmission
    function automatic ook_cmd_t noise_cmd();
        ook_cmd_t c;
        c      = random_fields();
        c.func = FUNC_FRAME;
        case ($urandom_range(4))
            0: c.end_marker = END_OK;
            1: c.header = HEADER_OK;
            2:
            begin
                c.header     = HEADER_OK;
                c.end_marker = END_OK;
            end
            3:
            begin
                c.header     = HEADER_OK;
                c.end_marker = END_OK;
                c.freq_code  = BAND_433;
            end
            default: ;
        endcase
        if (c.header == HEADER_OK && c.end_marker == END_OK && c.freq_code == BAND_433)
            c.repeat_count = 8'd0;
        return c;
    endfunction

    function automatic ook_cmd_t busy_cmd();
        ook_cmd_t c;
        c = random_fields();
        if ($urandom_range(1))
            c = frame_cmd(8'($urandom), 16'($urandom), 8'($urandom));
        c.func = FUNC_FRAME;
        return c;
    endfunction

    task automatic send_item(input ook_cmd_t c);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        drv      <= c;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic run_ticks_until_idle();
        while (sb.is_busy())
            send_item(tick_item());
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apb_read_check(input logic [2:0] addr, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== want)
        begin
            $error("prdata expected %h actual %h", want, prdata);
            cfg_errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_unit_ticks(input logic [15:0] value);
        wait_drain();
        apb_write(UNIT_TICKS_ADDR, {16'($urandom), value});
        sb.set_unit_ticks(value);
        apb_read_check(UNIT_TICKS_ADDR, {16'd0, value});
    endtask

    task automatic run_random(input int budget, input int max_reps, input bit idle_only);
        int       n;
        int       pick;
        ook_cmd_t c;
        n = 0;
        while (n < budget || sb.is_busy())
        begin
            pick = $urandom_range(99);
            if (sb.is_busy())
                c = (pick < 5) ? busy_cmd() : tick_item();
            else if (idle_only)
                c = (pick < 50) ? tick_item() : noise_cmd();
            else if (pick < 65)
                c = frame_cmd(8'($urandom_range(max_reps, 1)), 16'($urandom), 8'($urandom));
            else if (pick < 80)
                c = tick_item();
            else
                c = noise_cmd();
            send_item(c);
            n++;
        end
    endtask

    initial
    begin
        ook_cmd_t c;
        sb          = new();
        tx_idle_pct = 16;
        rx_idle_pct = 60;
        cfg_errors  = 0;
        cycles      = 0;
        hold_req    = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        drv         = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset unit length, idle block: ticks, wrapper and band rejections, zero-repeat frame
        apb_read_check(UNIT_TICKS_ADDR, {16'd0, UNIT_TICKS_RST});
        c = '1;
        c.func = FUNC_TICK;
        send_item(c);
        c = frame_cmd(8'd1, 16'h1234, 8'h56);
        c.header = 8'h00;
        send_item(c);
        c = frame_cmd(8'd1, 16'h1234, 8'h56);
        c.end_marker = 8'h00;
        send_item(c);
        c = frame_cmd(8'hFF, 16'hFFFF, 8'hFF);
        c.freq_code = 8'h00;
        send_item(c);
        c = frame_cmd(8'd1, 16'h0000, 8'h00);
        c.freq_code = 8'hFF;
        send_item(c);
        send_item(frame_cmd(8'd0, 16'hFFFF, 8'hFF));
        c = '0;
        send_item(c);

        // short units: full frames, commands while busy
        set_unit_ticks(16'd1);
        send_item(frame_cmd(8'd1, 16'hFFFF, 8'h00));
        send_item(busy_cmd());
        c = frame_cmd(8'd5, 16'h0F0F, 8'hAA);
        c.header = 8'h00;
        send_item(c);
        run_ticks_until_idle();
        send_item(frame_cmd(8'd2, 16'h0000, 8'hFF));
        run_ticks_until_idle();

        run_random(50, 2, 1'b0);
        set_unit_ticks(16'd2);
        run_random(40, 2, 1'b0);

        tx_idle_pct = 60;
        rx_idle_pct = 16;
        set_unit_ticks(16'd3);
        run_random(50, 1, 1'b0);
        wait_drain();
        apb_write(UNUSED_ADDR, $urandom);
        apb_read_check(UNIT_TICKS_ADDR, {16'd0, sb.unit_ticks});
        set_unit_ticks(16'hFFFF);
        run_random(50, 1, 1'b1);

        // zero unit length, repeated frame, long output stall while input keeps coming
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_unit_ticks(16'd0);
        send_item(frame_cmd(8'd2, 16'($urandom), 8'($urandom)));
        repeat (60) send_item(tick_item());
        hold_req = 1'b1;
        run_ticks_until_idle();
        set_unit_ticks(16'd1);
        run_random(50, 3, 1'b0);

        wait_drain();
        repeat (END_WAIT) @(negedge clk);
        if (sb.errors == 0 && cfg_errors == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
